// ===== hdl/ftt_pkg.sv =====
// Package for the framed transfer transmitter: job record, kind codes,
// sequencer step numbers, queue sizing and the byte-wise CRC-32 function.
// No dependencies.
package ftt_pkg;

  localparam logic [15:0] MAX_CHUNK = 16'd250;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [1:0] KIND_HDR  = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  localparam logic [3:0] STEP_FIRST    = 4'd0;
  localparam logic [3:0] STEP_MARK     = 4'd1;
  localparam logic [3:0] STEP_PAYLOAD  = 4'd2;
  localparam logic [3:0] STEP_DATA_CRC = 4'd3;
  localparam logic [3:0] STEP_DATA_END = 4'd6;
  localparam logic [3:0] STEP_LEN_HI   = 4'd3;
  localparam logic [3:0] STEP_LEN_LO   = 4'd4;
  localparam logic [3:0] STEP_HDR_CRC  = 4'd5;
  localparam logic [3:0] STEP_HDR_END  = 4'd8;

  localparam logic [7:0]  DATA_MARK = 8'h01;
  localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  addr_byte;
    logic [7:0]  byte1;
    logic [7:0]  byte2;
    logic [15:0] len;
    logic        open;
    logic        close;
    logic        done;
  } job_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== hdl/ftt_front.sv =====
// Front end of the framed transfer transmitter: accepts items, tracks the
// transfer and chunk counters and turns each item into a job record.
// Depends on ftt_pkg.
module ftt_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          acc,
  input  logic          op,
  input  logic [6:0]    peer_addr,
  input  logic [7:0]    msg_id,
  input  logic [7:0]    seq_nr,
  input  logic [15:0]   data_length,
  input  logic [7:0]    payload_byte,
  output ftt_pkg::job_t job
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_DATA = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;

  logic [1:0]  phase_r, phase_nxt;
  logic [6:0]  addr_r, addr_nxt;
  logic [15:0] total_r, total_nxt;
  logic [15:0] done_r, done_nxt;
  logic [15:0] chunk_r, chunk_nxt;
  logic [15:0] rem;
  logic [15:0] chunk_sel;
  logic        in_data;

  always_comb begin
    unique case (phase_r) inside
      PH_DATA: in_data = 1'b1;
      PH_IDLE, PH_DONE: in_data = 1'b0;
      default: in_data = 1'b0;
    endcase
  end

  always_comb begin
    rem       = total_r - done_r;
    chunk_sel = (chunk_r == 16'd0) ?
                ((rem < ftt_pkg::MAX_CHUNK) ? rem : ftt_pkg::MAX_CHUNK) : chunk_r;
    phase_nxt = phase_r;
    addr_nxt  = addr_r;
    total_nxt = total_r;
    done_nxt  = done_r;
    chunk_nxt = chunk_r;
    job.kind      = ftt_pkg::KIND_ERR;
    job.addr_byte = {addr_r, 1'b0};
    job.byte1     = payload_byte;
    job.byte2     = seq_nr;
    job.len       = data_length;
    job.open      = 1'b0;
    job.close     = 1'b0;
    job.done      = 1'b0;
    if (!op) begin
      addr_nxt      = peer_addr;
      total_nxt     = data_length;
      done_nxt      = 16'd0;
      chunk_nxt     = 16'd0;
      phase_nxt     = (data_length != 16'd0) ? PH_DATA : PH_DONE;
      job.kind      = ftt_pkg::KIND_HDR;
      job.addr_byte = {peer_addr, 1'b0};
      job.byte1     = msg_id;
      job.done      = (data_length == 16'd0);
    end else if (in_data) begin
      chunk_nxt = chunk_sel - 16'd1;
      done_nxt  = done_r + 16'd1;
      job.kind  = ftt_pkg::KIND_DATA;
      job.open  = (chunk_r == 16'd0);
      job.close = (chunk_nxt == 16'd0);
      job.done  = (done_nxt >= total_r);
      if (job.done) begin
        phase_nxt = PH_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      addr_r  <= 7'd0;
      total_r <= 16'd0;
      done_r  <= 16'd0;
      chunk_r <= 16'd0;
    end else if (acc) begin
      phase_r <= phase_nxt;
      addr_r  <= addr_nxt;
      total_r <= total_nxt;
      done_r  <= done_nxt;
      chunk_r <= chunk_nxt;
    end
  end

endmodule

// ===== hdl/ftt_queue.sv =====
// Short job queue between the front end and the frame sequencer.
// Depends on ftt_pkg for the job record and the queue depth.
module ftt_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ftt_pkg::job_t wr_job,
  input  logic          pop,
  output ftt_pkg::job_t rd_job,
  output logic          full,
  output logic          empty
);

  ftt_pkg::job_t            mem_r [ftt_pkg::QDEPTH];
  logic [ftt_pkg::QAW-1:0]  wp_r, rp_r;
  logic [ftt_pkg::QAW:0]    cnt_r;

  assign full   = (cnt_r == (ftt_pkg::QAW+1)'(ftt_pkg::QDEPTH));
  assign empty  = (cnt_r == '0);
  assign rd_job = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_job;
    end
  end

endmodule

// ===== hdl/ftt_back.sv =====
// Frame sequencer: expands each job into bus bytes, runs the CRC-32 and
// holds the result in an output register. Depends on ftt_pkg.
module ftt_back (
  input  logic          clk,
  input  logic          rst_n,
  input  ftt_pkg::job_t q_job,
  input  logic          q_empty,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          frame_end,
  output logic          last,
  output logic          transfer_done,
  output logic          status
);

  ftt_pkg::job_t job_r;
  logic          busy_r, busy_nxt;
  logic [3:0]    step_r, step_nxt;
  logic [31:0]   crc_r, crc_nxt;
  logic          ov_r, ov_nxt;
  logic [7:0]    ob_r;
  logic          ofe_r, olast_r, odone_r, ost_r;

  logic          adv, emit;
  logic [31:0]   crc_base, crc_fin;
  logic [7:0]    e_byte;
  logic          e_crc, e_last, e_status;
  logic [3:0]    crc_ofs;
  logic [1:0]    crc_idx;
  logic [7:0]    crc_out;

  assign adv   = !ov_r || out_ready;
  assign emit  = busy_r && adv;
  assign q_pop = !busy_r && !q_empty;

  always_comb begin
    crc_base = (step_r == ftt_pkg::STEP_FIRST) ? ftt_pkg::CRC_INIT : crc_r;
    crc_fin  = ~crc_r;
    e_byte   = 8'd0;
    e_crc    = 1'b0;
    e_last   = 1'b0;
    e_status = 1'b0;
    crc_ofs  = 4'd0;
    unique case (job_r.kind)
      ftt_pkg::KIND_HDR: begin
        crc_ofs = step_r - ftt_pkg::STEP_HDR_CRC;
        e_crc   = (step_r >= ftt_pkg::STEP_HDR_CRC);
        e_last  = (step_r == ftt_pkg::STEP_HDR_END);
        unique case (step_r)
          ftt_pkg::STEP_FIRST:   e_byte = job_r.addr_byte;
          ftt_pkg::STEP_MARK:    e_byte = job_r.byte1;
          ftt_pkg::STEP_PAYLOAD: e_byte = job_r.byte2;
          ftt_pkg::STEP_LEN_HI:  e_byte = job_r.len[15:8];
          ftt_pkg::STEP_LEN_LO:  e_byte = job_r.len[7:0];
          default:               e_byte = 8'd0;
        endcase
      end
      ftt_pkg::KIND_DATA: begin
        crc_ofs = step_r - ftt_pkg::STEP_DATA_CRC;
        e_crc   = (step_r >= ftt_pkg::STEP_DATA_CRC);
        e_last  = job_r.close ? (step_r == ftt_pkg::STEP_DATA_END)
                              : (step_r == ftt_pkg::STEP_PAYLOAD);
        unique case (step_r)
          ftt_pkg::STEP_FIRST:   e_byte = job_r.addr_byte;
          ftt_pkg::STEP_MARK:    e_byte = ftt_pkg::DATA_MARK;
          ftt_pkg::STEP_PAYLOAD: e_byte = job_r.byte1;
          default:               e_byte = 8'd0;
        endcase
      end
      default: begin
        e_last   = 1'b1;
        e_status = 1'b1;
      end
    endcase
    crc_idx = crc_ofs[1:0];
    unique case (crc_idx)
      2'd0:    crc_out = crc_fin[31:24];
      2'd1:    crc_out = crc_fin[23:16];
      2'd2:    crc_out = crc_fin[15:8];
      default: crc_out = crc_fin[7:0];
    endcase
  end

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    crc_nxt  = crc_r;
    ov_nxt   = ov_r;
    if (adv) begin
      ov_nxt = emit;
    end
    if (q_pop) begin
      busy_nxt = 1'b1;
      step_nxt = (q_job.kind == ftt_pkg::KIND_DATA && !q_job.open) ?
                 ftt_pkg::STEP_PAYLOAD : ftt_pkg::STEP_FIRST;
    end else if (emit) begin
      if (e_last) begin
        busy_nxt = 1'b0;
      end else begin
        step_nxt = step_r + 4'd1;
      end
      if (!e_crc) begin
        crc_nxt = ftt_pkg::crc_byte(crc_base, e_byte);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= ftt_pkg::STEP_FIRST;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    crc_r <= crc_nxt;
    if (q_pop) begin
      job_r <= q_job;
    end
    if (emit) begin
      ob_r    <= e_crc ? crc_out : e_byte;
      ofe_r   <= e_crc && (crc_idx == 2'd3);
      olast_r <= e_last;
      odone_r <= e_last && job_r.done && !e_status;
      ost_r   <= e_status;
    end
  end

  assign out_valid     = ov_r;
  assign out_byte      = ob_r;
  assign frame_end     = ofe_r;
  assign last          = olast_r;
  assign transfer_done = odone_r;
  assign status        = ost_r;

endmodule

// ===== hdl/framed_transfer_transmitter_unit.sv =====
// Top level of the framed transfer transmitter: front end, job queue and
// frame sequencer. Depends on ftt_pkg, ftt_front, ftt_queue and ftt_back.
//
// Channel  Direction  Transfer contents
// in_*     slave      one start item or one payload byte
// out_*    master     one bus byte with frame and status flags
//
// A start item causes 9 output bytes, a payload byte 1 to 7, an unexpected
// payload byte one error result. The frame sequencer emits one byte per cycle
// while its output register is empty or being read, and takes the next job
// from the queue only after the current job's last byte. The front end accepts
// one item per cycle while the four-entry queue has room. Reset is
// synchronous and active low and clears all control state.
module framed_transfer_transmitter_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,  // peer_addr, msg_id, seq_nr, data_length, payload_byte, zeros
  input  logic [0:0]  in_tuser,  // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata, // out_byte
  output logic        out_tlast,
  output logic [2:0]  out_tuser  // last, transfer_done, status
);

  ftt_pkg::job_t f_job;
  ftt_pkg::job_t q_job;
  logic          acc, q_full, q_empty, q_pop;

  assign in_tready = !q_full;
  assign acc       = in_tvalid && in_tready;

  ftt_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .acc          (acc),
    .op           (in_tuser[0]),
    .peer_addr    (in_tdata[6:0]),
    .msg_id       (in_tdata[14:7]),
    .seq_nr       (in_tdata[22:15]),
    .data_length  (in_tdata[38:23]),
    .payload_byte (in_tdata[46:39]),
    .job          (f_job)
  );

  ftt_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (acc),
    .wr_job (f_job),
    .pop    (q_pop),
    .rd_job (q_job),
    .full   (q_full),
    .empty  (q_empty)
  );

  ftt_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_job         (q_job),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_byte      (out_tdata),
    .frame_end     (out_tlast),
    .last          (out_tuser[0]),
    .transfer_done (out_tuser[1]),
    .status        (out_tuser[2])
  );

endmodule

// ===== test/framed_transfer_transmitter_unit_test.sv =====
// Self-checking testbench for framed_transfer_transmitter_unit: a scoreboard predicts every
// header, data and error byte from the accepted items and checks each output transfer.
// Depends on ftt_pkg and the framed_transfer_transmitter_unit RTL.
`timescale 1ns / 1ps

module framed_transfer_transmitter_unit_test;

  localparam logic OP_START   = 1'b0;
  localparam logic OP_PAYLOAD = 1'b1;
  localparam int   CYCLE_LIMIT = 400000;
  localparam int   ITEM_TARGET = 330;

  typedef enum logic [1:0] {XFER_IDLE, XFER_DATA, XFER_DONE} xfer_phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       frame_end;
    logic       last;
    logic       done;
    logic       status;
  } bus_byte_t;

  class tx_frame_scoreboard_t;
    xfer_phase_t phase;
    logic [6:0]  target;
    logic [15:0] total_len;
    logic [15:0] sent;
    logic [15:0] chunk_left;
    logic [31:0] crc_acc;
    bus_byte_t   bytes_due[$];
    bus_byte_t   item_bytes[$];
    int mismatches, starts, payloads, strays, frames, finished, outputs;

    function new();
      phase      = XFER_IDLE;
      target     = '0;
      total_len  = '0;
      sent       = '0;
      chunk_left = '0;
      crc_acc    = '1;
      mismatches = 0;
      starts     = 0;
      payloads   = 0;
      strays     = 0;
      frames     = 0;
      finished   = 0;
      outputs    = 0;
    endfunction

    function logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
      logic fb;
      for (int n = 0; n < 8; n++) begin
        fb = c[0] ^ b[n];
        c = c >> 1;
        if (fb) c = c ^ 32'hEDB8_8320;
      end
      return c;
    endfunction

    function void emit(logic [7:0] d, logic fe);
      bus_byte_t r;
      r = '0;
      r.data = d;
      r.frame_end = fe;
      item_bytes.push_back(r);
    endfunction

    function void emit_crc(logic [31:0] c);
      logic [31:0] v;
      v = ~c;
      emit(v[31:24], 1'b0);
      emit(v[23:16], 1'b0);
      emit(v[15:8], 1'b0);
      emit(v[7:0], 1'b1);
    endfunction

    function void note_input(logic op, logic [47:0] w);
      logic [7:0]  hdr[5];
      logic [31:0] c;
      logic [15:0] rem;
      logic [7:0]  addr_byte;
      logic        completes;
      bus_byte_t   r;
      item_bytes.delete();
      completes = 1'b0;
      if (op == OP_START) begin
        starts++;
        target = w[6:0];
        total_len = w[38:23];
        sent = '0;
        chunk_left = '0;
        hdr[0] = {target, 1'b0};
        hdr[1] = w[14:7];
        hdr[2] = w[22:15];
        hdr[3] = total_len[15:8];
        hdr[4] = total_len[7:0];
        c = '1;
        for (int i = 0; i < 5; i++) begin
          c = crc_step(c, hdr[i]);
          emit(hdr[i], 1'b0);
        end
        emit_crc(c);
        crc_acc = '1;
        phase = (total_len != 0) ? XFER_DATA : XFER_DONE;
        completes = (phase == XFER_DONE);
      end else if (phase != XFER_DATA) begin
        strays++;
        r = '0;
        r.status = 1'b1;
        item_bytes.push_back(r);
      end else begin
        payloads++;
        if (chunk_left == 0) begin
          rem = total_len - sent;
          chunk_left = (rem < ftt_pkg::MAX_CHUNK) ? rem : ftt_pkg::MAX_CHUNK;
          addr_byte = {target, 1'b0};
          crc_acc = crc_step(32'hFFFF_FFFF, addr_byte);
          crc_acc = crc_step(crc_acc, 8'h01);
          emit(addr_byte, 1'b0);
          emit(8'h01, 1'b0);
        end
        crc_acc = crc_step(crc_acc, w[46:39]);
        emit(w[46:39], 1'b0);
        chunk_left = chunk_left - 1'b1;
        sent = sent + 1'b1;
        if (chunk_left == 0) begin
          emit_crc(crc_acc);
          crc_acc = '1;
        end
        if (sent >= total_len) begin
          phase = XFER_DONE;
          completes = 1'b1;
        end
      end
      r = item_bytes.pop_back();
      r.last = 1'b1;
      r.done = completes;
      item_bytes.push_back(r);
      foreach (item_bytes[i]) bytes_due.push_back(item_bytes[i]);
    endfunction

    task report(string msg);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(logic [7:0] d, logic fe, logic [2:0] u);
      bus_byte_t want;
      outputs++;
      if (bytes_due.size() == 0) begin
        report($sformatf("output transfer %02h with nothing pending", d));
        return;
      end
      want = bytes_due.pop_front();
      if (d !== want.data)
        report($sformatf("out byte %02h, predicted %02h", d, want.data));
      if (fe !== want.frame_end)
        report($sformatf("frame end %b, predicted %b (byte %02h)", fe, want.frame_end, d));
      if (u[0] !== want.last)
        report($sformatf("last %b, predicted %b (byte %02h)", u[0], want.last, d));
      if (u[1] !== want.done)
        report($sformatf("transfer done %b, predicted %b (byte %02h)", u[1], want.done, d));
      if (u[2] !== want.status)
        report($sformatf("status %b, predicted %b (byte %02h)", u[2], want.status, d));
      if (want.frame_end) frames++;
      if (want.done) finished++;
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic [0:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic [2:0]  out_tuser;

  logic in_burst;
  logic out_burst;
  int   cycles;
  tx_frame_scoreboard_t sb;

  framed_transfer_transmitter_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Run stopped at the cycle limit with %0d bytes outstanding.", sb.bytes_due.size());
    $display("** framed_transfer_transmitter_unit: FAILED **");
    $finish;
  end

  task automatic push_item(logic op, logic [46:0] fields);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 16);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {1'b0, fields};
    do @(posedge clk); while (!in_tready);
    sb.note_input(in_tuser[0], in_tdata);
  endtask

  task automatic send_start(logic [6:0] a, logic [7:0] m, logic [7:0] s, logic [15:0] len);
    push_item(OP_START, {8'($urandom), len, s, m, a});
  endtask

  task automatic send_payload(logic [7:0] b);
    push_item(OP_PAYLOAD, {b, 39'({$urandom, $urandom})});
  endtask

  task automatic run_transfer(int len, int stop_at);
    send_start(7'($urandom), 8'($urandom), 8'($urandom), 16'(len));
    for (int i = 0; i < len; i++) begin
      if (i == stop_at) break;
      send_payload(8'($urandom));
    end
  endtask

  initial begin
    out_tready = 1'b0;
    out_burst  = 1'b0;
    @(posedge clk);
    wait (rst_n === 1'b1);
    forever begin
      int stall;
      stall = out_burst ? 0 : $urandom_range(0, 16);
      @(negedge clk);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_result(out_tdata, out_tlast, out_tuser);
      if ($urandom_range(0, 23) == 0) out_burst = ~out_burst;
    end
  end

  initial begin
    int  len;
    int  pick;
    bit  long_done;
    sb        = new();
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    in_burst  = 1'b0;
    long_done = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_payload(8'hFF);
    send_start(7'h7F, 8'hFF, 8'hFF, 16'h0000);
    send_payload(8'h00);
    send_start(7'h00, 8'h00, 8'h00, 16'd3);
    send_payload(8'h00);
    send_payload(8'hFF);
    send_payload(8'h5A);
    send_payload(8'hC3);
    send_start(7'h55, 8'hA5, 8'h3C, 16'hFFFF);
    send_payload(8'h12);
    send_payload(8'h34);
    send_start(7'h2A, 8'h5A, 8'hC3, 16'd1);
    send_payload(8'h81);
    send_start(7'h01, 8'h7E, 8'h80, 16'd2);
    send_payload(8'h99);
    send_start(7'h40, 8'h01, 8'h02, 16'h8000);
    send_payload(8'h66);
    send_start(7'h3F, 8'h10, 8'h20, 16'h0000);

    while (sb.starts + sb.payloads + sb.strays < ITEM_TARGET) begin
      in_burst = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (!long_done && sb.starts + sb.payloads > 40) begin
        run_transfer(int'(ftt_pkg::MAX_CHUNK) + $urandom_range(1, 5), -1);
        long_done = 1'b1;
      end else if (pick < 75) begin
        len = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 12);
        run_transfer(len, ($urandom_range(0, 9) == 0) ? $urandom_range(0, len) : -1);
        if ($urandom_range(0, 7) == 0) send_payload(8'($urandom));
      end else begin
        push_item(1'($urandom), 47'({$urandom, $urandom}));
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.bytes_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Sent %0d starts, %0d framed payload bytes and %0d stray bytes.",
             sb.starts, sb.payloads, sb.strays);
    $display("Checked %0d output transfers: %0d frames closed, %0d transfers finished.",
             sb.outputs, sb.frames, sb.finished);
    if (sb.mismatches == 0) begin
      $display("** framed_transfer_transmitter_unit: PASSED **");
    end else begin
      $display("** framed_transfer_transmitter_unit: FAILED **");
    end
    $finish;
  end

endmodule
